@@ rtl/core/alu_pkg.sv @@
// Shared types, constants, sigmoid table and saturation helpers for the activation/loss unit.
`timescale 1ns / 1ps
`default_nettype none
package alu_pkg;

  // Fixed element format
  localparam int unsigned DATA_WIDTH    = 16;
  localparam int unsigned DEF_FRAC_BITS = 12;

  // Sigmoid table: 65 samples, every 1/8 over [0, 8], values in Q0.30
  localparam int unsigned TBL_N     = 65;
  localparam int unsigned TBL_IDX_W = 7;
  localparam int unsigned SEG_W     = 6;
  localparam int unsigned TBL_W     = 30;
  localparam int unsigned V_W       = 31;
  localparam int unsigned P_W       = 62;
  localparam logic [63:0] EXP_STEP_Q32 = 64'd3790295335;
  localparam logic [V_W-1:0] ONE_Q30   = V_W'(1) << 30;

  // Result bounds
  localparam logic signed [DATA_WIDTH-1:0] RES_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] RES_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Operation codes
  typedef enum logic [2:0] {
    FUNC_SIGMOID    = 3'd0,
    FUNC_SIG_DERIV  = 3'd1,
    FUNC_RELU       = 3'd2,
    FUNC_RELU_DERIV = 3'd3,
    FUNC_IDENTITY   = 3'd4,
    FUNC_HALF_SQ    = 3'd5,
    FUNC_ERR_DERIV  = 3'd6
  } func_e;

  // Input and result transactions
  typedef struct packed {
    logic [2:0]                   func;
    logic signed [DATA_WIDTH-1:0] operand_a;
    logic signed [DATA_WIDTH-1:0] operand_b;
  } alu_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] result_value;
    logic                         saturated;
  } alu_out_t;

  // Control that travels with each pipeline stage
  typedef struct packed {
    logic  valid;
    func_e func;
    logic  neg;
  } alu_ctrl_t;

  typedef logic [TBL_W-1:0] sig_tbl_t [TBL_N];

  // Build the sigmoid table: exp(-k/8) by a Q0.32 recurrence, then 1/(1+e) by long division
  function automatic sig_tbl_t build_sig_tbl();
    sig_tbl_t    tbl;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] quo;
    logic [64:0] rem;
    e = 64'h1_0000_0000;
    for (int k = 0; k < TBL_N; k++) begin
      if (k > 0) begin
        e = (e * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
      end
      den = 64'h1_0000_0000 + e;
      num = (64'd1 << 62) + (den >> 1);
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
        rem = {rem[63:0], num[i]};
        if (rem >= {1'b0, den}) begin
          rem    = rem - {1'b0, den};
          quo[i] = 1'b1;
        end
      end
      tbl[k] = quo[TBL_W-1:0];
    end
    return tbl;
  endfunction

  localparam sig_tbl_t SIG_TBL = build_sig_tbl();

  // Clip a non-negative value to the top of the signed range
  function automatic alu_out_t sat_unsigned(logic [63:0] x);
    alu_out_t r;
    if (x > 64'(RES_MAX)) begin
      r.result_value = RES_MAX;
      r.saturated    = 1'b1;
    end else begin
      r.result_value = x[DATA_WIDTH-1:0];
      r.saturated    = 1'b0;
    end
    return r;
  endfunction

  // Clip a value one bit wider than the element to the signed range
  function automatic alu_out_t sat_signed(logic signed [DATA_WIDTH:0] x);
    alu_out_t r;
    if (x > $signed({RES_MAX[DATA_WIDTH-1], RES_MAX})) begin
      r.result_value = RES_MAX;
      r.saturated    = 1'b1;
    end else if (x < $signed({RES_MIN[DATA_WIDTH-1], RES_MIN})) begin
      r.result_value = RES_MIN;
      r.saturated    = 1'b1;
    end else begin
      r.result_value = x[DATA_WIDTH-1:0];
      r.saturated    = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/alu_front.sv @@
// Stage 1: operation decode, sigmoid segment lookup and operand difference.
`timescale 1ns / 1ps
`default_nettype none
module alu_front #(
  parameter int unsigned FRAC_BITS = alu_pkg::DEF_FRAC_BITS
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   advance_i,
  input  wire logic                                   valid_i,
  input  wire alu_pkg::alu_in_t                       data_i,
  output alu_pkg::alu_ctrl_t                          ctrl_o,
  output logic [alu_pkg::TBL_W-1:0]                   lo_o,
  output logic [alu_pkg::TBL_W-1:0]                   diff_o,
  output logic [FRAC_BITS-4:0]                        frac_o,
  output logic signed [alu_pkg::DATA_WIDTH-1:0]       a_o,
  output logic signed [alu_pkg::DATA_WIDTH:0]         d_o
);

  localparam int unsigned DW = alu_pkg::DATA_WIDTH;
  localparam int unsigned SH = FRAC_BITS - 3;
  localparam int unsigned MW = DW + SH;

  logic [DW-1:0]                 mag;
  logic [MW-1:0]                 mag_w;
  logic [MW-1:0]                 seg_full;
  logic                          past_end;
  logic [alu_pkg::TBL_IDX_W-1:0] idx_lo;
  logic [alu_pkg::TBL_IDX_W-1:0] idx_hi;
  logic [alu_pkg::TBL_W-1:0]     lo_val;
  logic [alu_pkg::TBL_W-1:0]     hi_val;

  alu_pkg::alu_ctrl_t            ctrl_d, ctrl_q;
  logic [alu_pkg::TBL_W-1:0]     lo_d, lo_q;
  logic [alu_pkg::TBL_W-1:0]     diff_d, diff_q;
  logic [SH-1:0]                 frac_d, frac_q;
  logic signed [DW-1:0]          a_d, a_q;
  logic signed [DW:0]            d_d, d_q;

  // Split |a| into table segment and fraction within the segment
  always_comb begin
    mag      = data_i.operand_a[DW-1] ? (~data_i.operand_a + 1'b1) : data_i.operand_a;
    mag_w    = {{SH{1'b0}}, mag};
    seg_full = mag_w >> SH;
    past_end = seg_full >= MW'(alu_pkg::TBL_N - 1);
    idx_lo   = {1'b0, seg_full[alu_pkg::SEG_W-1:0]};
    idx_hi   = idx_lo + 1'b1;
    frac_d   = mag_w[SH-1:0];
  end

  // Read both segment ends; hold the last entry beyond the table
  always_comb begin
    lo_val = past_end ? alu_pkg::SIG_TBL[alu_pkg::TBL_N-1] : alu_pkg::SIG_TBL[idx_lo];
    hi_val = past_end ? alu_pkg::SIG_TBL[alu_pkg::TBL_N-1] : alu_pkg::SIG_TBL[idx_hi];
    lo_d   = lo_val;
    diff_d = hi_val - lo_val;
  end

  // Decode and form the exact difference for the loss operations
  always_comb begin
    ctrl_d.valid = valid_i;
    ctrl_d.func  = alu_pkg::func_e'(data_i.func);
    ctrl_d.neg   = data_i.operand_a[DW-1];
    a_d          = data_i.operand_a;
    d_d          = {data_i.operand_a[DW-1], data_i.operand_a}
                 - {data_i.operand_b[DW-1], data_i.operand_b};
  end

  // Advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (advance_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      lo_q   <= lo_d;
      diff_q <= diff_d;
      frac_q <= frac_d;
      a_q    <= a_d;
      d_q    <= d_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign lo_o   = lo_q;
  assign diff_o = diff_q;
  assign frac_o = frac_q;
  assign a_o    = a_q;
  assign d_o    = d_q;

endmodule
`default_nettype wire

@@ rtl/core/alu_mul.sv @@
// Stage 2: interpolation product and squared error product.
`timescale 1ns / 1ps
`default_nettype none
module alu_mul #(
  parameter int unsigned FRAC_BITS = alu_pkg::DEF_FRAC_BITS
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   advance_i,
  input  wire alu_pkg::alu_ctrl_t                     ctrl_i,
  input  wire logic [alu_pkg::TBL_W-1:0]              lo_i,
  input  wire logic [alu_pkg::TBL_W-1:0]              diff_i,
  input  wire logic [FRAC_BITS-4:0]                   frac_i,
  input  wire logic signed [alu_pkg::DATA_WIDTH-1:0]  a_i,
  input  wire logic signed [alu_pkg::DATA_WIDTH:0]    d_i,
  output alu_pkg::alu_ctrl_t                          ctrl_o,
  output logic [alu_pkg::TBL_W-1:0]                   lo_o,
  output logic [alu_pkg::TBL_W+FRAC_BITS-4:0]         prod_o,
  output logic [2*alu_pkg::DATA_WIDTH-1:0]            sq_o,
  output logic signed [alu_pkg::DATA_WIDTH-1:0]       a_o,
  output logic signed [alu_pkg::DATA_WIDTH:0]         d_o
);

  localparam int unsigned DW   = alu_pkg::DATA_WIDTH;
  localparam int unsigned SH   = FRAC_BITS - 3;
  localparam int unsigned PR_W = alu_pkg::TBL_W + SH;
  localparam int unsigned SQ_W = 2 * DW;

  logic [DW:0]                dneg;
  logic [DW-1:0]              dmag;

  alu_pkg::alu_ctrl_t         ctrl_q;
  logic [alu_pkg::TBL_W-1:0]  lo_q;
  logic [PR_W-1:0]            prod_d, prod_q;
  logic [SQ_W-1:0]            sq_d, sq_q;
  logic signed [DW-1:0]       a_q;
  logic signed [DW:0]         d_q;

  // Multiply slope by fraction, and |a-b| by itself
  always_comb begin
    dneg   = ~d_i + 1'b1;
    dmag   = d_i[DW] ? dneg[DW-1:0] : d_i[DW-1:0];
    prod_d = PR_W'(diff_i) * PR_W'(frac_i);
    sq_d   = SQ_W'(dmag) * SQ_W'(dmag);
  end

  // Advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (advance_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      lo_q   <= lo_i;
      prod_q <= prod_d;
      sq_q   <= sq_d;
      a_q    <= a_i;
      d_q    <= d_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign lo_o   = lo_q;
  assign prod_o = prod_q;
  assign sq_o   = sq_q;
  assign a_o    = a_q;
  assign d_o    = d_q;

endmodule
`default_nettype wire

@@ rtl/core/alu_sig.sv @@
// Stage 3: sigmoid interpolation sum and reflection for negative inputs.
`timescale 1ns / 1ps
`default_nettype none
module alu_sig #(
  parameter int unsigned FRAC_BITS = alu_pkg::DEF_FRAC_BITS
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   advance_i,
  input  wire alu_pkg::alu_ctrl_t                     ctrl_i,
  input  wire logic [alu_pkg::TBL_W-1:0]              lo_i,
  input  wire logic [alu_pkg::TBL_W+FRAC_BITS-4:0]    prod_i,
  input  wire logic [2*alu_pkg::DATA_WIDTH-1:0]       sq_i,
  input  wire logic signed [alu_pkg::DATA_WIDTH-1:0]  a_i,
  input  wire logic signed [alu_pkg::DATA_WIDTH:0]    d_i,
  output alu_pkg::alu_ctrl_t                          ctrl_o,
  output logic [alu_pkg::V_W-1:0]                     v_o,
  output logic [2*alu_pkg::DATA_WIDTH-1:0]            sq_o,
  output logic signed [alu_pkg::DATA_WIDTH-1:0]       a_o,
  output logic signed [alu_pkg::DATA_WIDTH:0]         d_o
);

  localparam int unsigned DW   = alu_pkg::DATA_WIDTH;
  localparam int unsigned SH   = FRAC_BITS - 3;
  localparam int unsigned PR_W = alu_pkg::TBL_W + SH;
  localparam int unsigned SQ_W = 2 * DW;

  logic [PR_W-1:0]             prod_sh;
  logic [alu_pkg::V_W-1:0]     v_pos;

  alu_pkg::alu_ctrl_t          ctrl_q;
  logic [alu_pkg::V_W-1:0]     v_d, v_q;
  logic [SQ_W-1:0]             sq_q;
  logic signed [DW-1:0]        a_q;
  logic signed [DW:0]          d_q;

  // Add the interpolated step, then mirror about one half for negative x
  always_comb begin
    prod_sh = prod_i >> SH;
    v_pos   = alu_pkg::V_W'(lo_i) + alu_pkg::V_W'(prod_sh[alu_pkg::TBL_W-1:0]);
    v_d     = ctrl_i.neg ? (alu_pkg::ONE_Q30 - v_pos) : v_pos;
  end

  // Advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (advance_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      v_q  <= v_d;
      sq_q <= sq_i;
      a_q  <= a_i;
      d_q  <= d_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign v_o    = v_q;
  assign sq_o   = sq_q;
  assign a_o    = a_q;
  assign d_o    = d_q;

endmodule
`default_nettype wire

@@ rtl/core/alu_back.sv @@
// Stages 4 and 5: derivative product, rounding, saturation, result select and output register.
`timescale 1ns / 1ps
`default_nettype none
module alu_back #(
  parameter int unsigned FRAC_BITS = alu_pkg::DEF_FRAC_BITS
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   advance_i,
  input  wire alu_pkg::alu_ctrl_t                     ctrl_i,
  input  wire logic [alu_pkg::V_W-1:0]                v_i,
  input  wire logic [2*alu_pkg::DATA_WIDTH-1:0]       sq_i,
  input  wire logic signed [alu_pkg::DATA_WIDTH-1:0]  a_i,
  input  wire logic signed [alu_pkg::DATA_WIDTH:0]    d_i,
  output logic                                        valid_o,
  output alu_pkg::alu_out_t                           data_o
);

  localparam int unsigned DW   = alu_pkg::DATA_WIDTH;
  localparam int unsigned V_W  = alu_pkg::V_W;
  localparam int unsigned P_W  = alu_pkg::P_W;
  localparam int unsigned SQ_W = 2 * DW;

  logic [V_W-1:0]          omv;
  logic [V_W:0]            sig_sum;
  logic [SQ_W:0]           hsq_sum;
  logic [P_W:0]            der_sum;
  alu_pkg::alu_out_t       res;

  alu_pkg::alu_ctrl_t      ctrl_q;
  logic [P_W-1:0]          p_d, p_q;
  logic [V_W:0]            sig_d, sig_q;
  logic [SQ_W:0]           hsq_d, hsq_q;
  logic signed [DW-1:0]    a_q;
  logic signed [DW:0]      d_q;

  logic                    out_valid_q;
  alu_pkg::alu_out_t       out_data_q;

  // Stage 4: s*(1-s), rounded sigmoid and rounded half square
  always_comb begin
    omv     = alu_pkg::ONE_Q30 - v_i;
    p_d     = P_W'(v_i) * P_W'(omv);
    sig_sum = {1'b0, v_i} + ((V_W + 1)'(1) << (29 - FRAC_BITS));
    sig_d   = sig_sum >> (30 - FRAC_BITS);
    hsq_sum = {1'b0, sq_i} + ((SQ_W + 1)'(1) << FRAC_BITS);
    hsq_d   = hsq_sum >> (FRAC_BITS + 1);
  end

  // Advance the stage 4 valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (advance_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  // Advance the stage 4 payload
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      p_q   <= p_d;
      sig_q <= sig_d;
      hsq_q <= hsq_d;
      a_q   <= a_i;
      d_q   <= d_i;
    end
  end

  // Stage 5: round the derivative and pick the result by operation
  always_comb begin
    der_sum = {1'b0, p_q} + ((P_W + 1)'(1) << (59 - FRAC_BITS));
    res     = '0;
    case (ctrl_q.func)
      alu_pkg::FUNC_SIGMOID: begin
        res = alu_pkg::sat_unsigned(64'(sig_q));
      end
      alu_pkg::FUNC_SIG_DERIV: begin
        res = alu_pkg::sat_unsigned(64'(der_sum >> (60 - FRAC_BITS)));
      end
      alu_pkg::FUNC_RELU: begin
        if (!a_q[DW-1]) begin
          res.result_value = a_q;
        end
      end
      alu_pkg::FUNC_RELU_DERIV: begin
        if (!a_q[DW-1] && (a_q != '0)) begin
          res = alu_pkg::sat_unsigned(64'd1 << FRAC_BITS);
        end
      end
      alu_pkg::FUNC_IDENTITY: begin
        res.result_value = a_q;
      end
      alu_pkg::FUNC_HALF_SQ: begin
        res = alu_pkg::sat_unsigned(64'(hsq_q));
      end
      alu_pkg::FUNC_ERR_DERIV: begin
        res = alu_pkg::sat_signed(d_q);
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_i) begin
      out_valid_q <= ctrl_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      out_data_q <= res;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

endmodule
`default_nettype wire

@@ rtl/core/activation_loss_unit.sv @@
// Top level of the activation/loss unit: five-stage pipeline and valid/stall handshake.
`timescale 1ns / 1ps
`default_nettype none
// Elementwise activation and loss unit in signed fixed point (Q4.12 by default). Each input
// transaction carries func, operand_a and operand_b and yields exactly one result with a
// saturation flag: sigmoid, sigmoid derivative, ReLU, ReLU derivative, identity, half squared
// error and error derivative; an undefined func gives zero. Sigmoid interpolates a 65-entry
// constant table over |x| in [0, 8] with steps of 1/8. The unit takes one transaction per
// cycle while in_stall_o is low and passes it through table lookup, multiply, interpolate,
// derivative multiply and round-and-saturate stages into the output register. All stages
// move together: a result held in the output register by out_stall_i freezes the pipeline
// and raises in_stall_o, so throughput is one per cycle whenever the consumer takes results.
module activation_loss_unit #(
  parameter int unsigned FRAC_BITS = alu_pkg::DEF_FRAC_BITS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire alu_pkg::alu_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output alu_pkg::alu_out_t      out_data_o
);

  localparam int unsigned DW   = alu_pkg::DATA_WIDTH;
  localparam int unsigned SH   = FRAC_BITS - 3;
  localparam int unsigned PR_W = alu_pkg::TBL_W + SH;
  localparam int unsigned SQ_W = 2 * DW;

  logic                       advance;

  alu_pkg::alu_ctrl_t         s1_ctrl, s2_ctrl, s3_ctrl;
  logic [alu_pkg::TBL_W-1:0]  s1_lo, s1_diff, s2_lo;
  logic [SH-1:0]              s1_frac;
  logic signed [DW-1:0]       s1_a, s2_a, s3_a;
  logic signed [DW:0]         s1_d, s2_d, s3_d;
  logic [PR_W-1:0]            s2_prod;
  logic [SQ_W-1:0]            s2_sq, s3_sq;
  logic [alu_pkg::V_W-1:0]    s3_v;

  // Move every stage unless a finished result is waiting on the consumer
  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = !advance;

  alu_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .valid_i   (in_valid_i),
    .data_i    (in_data_i),
    .ctrl_o    (s1_ctrl),
    .lo_o      (s1_lo),
    .diff_o    (s1_diff),
    .frac_o    (s1_frac),
    .a_o       (s1_a),
    .d_o       (s1_d)
  );

  alu_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .ctrl_i    (s1_ctrl),
    .lo_i      (s1_lo),
    .diff_i    (s1_diff),
    .frac_i    (s1_frac),
    .a_i       (s1_a),
    .d_i       (s1_d),
    .ctrl_o    (s2_ctrl),
    .lo_o      (s2_lo),
    .prod_o    (s2_prod),
    .sq_o      (s2_sq),
    .a_o       (s2_a),
    .d_o       (s2_d)
  );

  alu_sig #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sig (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .ctrl_i    (s2_ctrl),
    .lo_i      (s2_lo),
    .prod_i    (s2_prod),
    .sq_i      (s2_sq),
    .a_i       (s2_a),
    .d_i       (s2_d),
    .ctrl_o    (s3_ctrl),
    .v_o       (s3_v),
    .sq_o      (s3_sq),
    .a_o       (s3_a),
    .d_o       (s3_d)
  );

  alu_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .ctrl_i    (s3_ctrl),
    .v_i       (s3_v),
    .sq_i      (s3_sq),
    .a_i       (s3_a),
    .d_i       (s3_d),
    .valid_o   (out_valid_o),
    .data_o    (out_data_o)
  );

`ifndef SYNTHESIS
  // The input is held back only by a waiting, stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // A flagged result sits on one of the range bounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.saturated) |->
      ((out_data_o.result_value == alu_pkg::RES_MAX) ||
       (out_data_o.result_value == alu_pkg::RES_MIN)))
    else $error("saturation flag set on an unclipped result");

  // An accepted transaction reaches the first stage register on the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_valid_i) |=> s1_ctrl.valid)
    else $error("accepted transaction lost at the first stage");

  // A stalled pipeline keeps its stage valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(s2_ctrl.valid) && $stable(s3_ctrl.valid)))
    else $error("stage valid changed during a stall");
`endif

endmodule
`default_nettype wire
